FILE: sv/crcfc_pkg.sv
// Shared types, constants and the CRC step for the response frame checker.
package crcfc_pkg;

	localparam int unsigned MIN_FRAME_BYTES = 8;
	localparam int unsigned CNT_W           = 4;

	localparam logic [7:0]  NEG_RESP_CHAR = 8'h4E;  // 'N'
	localparam logic [16:0] LEN_EXTRA     = 17'd3;

	// Register map: word index taken from paddr[3:2]
	localparam logic [1:0] REG_POLY = 2'd0;
	localparam logic [1:0] REG_SEED = 2'd1;
	localparam logic [1:0] REG_CMD  = 2'd2;

	localparam logic [15:0] POLY_RESET = 16'h1021;
	localparam logic [15:0] SEED_RESET = 16'h0000;
	localparam logic [15:0] CMD_RESET  = 16'h0000;

	typedef enum logic [2:0] {
		CHK_OK        = 3'd0,
		CHK_SHORT     = 3'd1,
		CHK_CMD_MISM  = 3'd2,
		CHK_CRC_MISM  = 3'd3,
		CHK_NEG_RESP  = 3'd4
	} check_status_t;

	typedef struct packed {
		logic [15:0] poly;
		logic [15:0] seed;
		logic [15:0] cmd;
	} cfg_t;

	typedef struct packed {
		logic [15:0]   computed_crc;
		logic [16:0]   payload_length;
		logic [15:0]   device_status;
		check_status_t check_status;
	} result_t;

	// One byte through an MSB-first CRC-16, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		logic        top;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			top = c[15] ^ b[i];
			c   = {c[14:0], 1'b0};
			if (top) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/crcfc_cfg_regs.sv
// APB configuration registers: polynomial, seed and expected command.
module crcfc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output crcfc_pkg::cfg_t    cfg
);

	logic [15:0] poly_q;
	logic [15:0] seed_q;
	logic [15:0] cmd_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crcfc_pkg::POLY_RESET;
			seed_q <= crcfc_pkg::SEED_RESET;
			cmd_q  <= crcfc_pkg::CMD_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				crcfc_pkg::REG_POLY: poly_q <= pwdata[15:0];
				crcfc_pkg::REG_SEED: seed_q <= pwdata[15:0];
				crcfc_pkg::REG_CMD:  cmd_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			crcfc_pkg::REG_POLY: prdata = {16'h0000, poly_q};
			crcfc_pkg::REG_SEED: prdata = {16'h0000, seed_q};
			crcfc_pkg::REG_CMD:  prdata = {16'h0000, cmd_q};
			default:             prdata = 32'h0000_0000;
		endcase
	end

	assign cfg.poly = poly_q;
	assign cfg.seed = seed_q;
	assign cfg.cmd  = cmd_q;

endmodule

FILE: sv/crcfc_frame_check.sv
// Per-frame state, byte-wide CRC update and end-of-frame checks.
module crcfc_frame_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_end,
	input  crcfc_pkg::cfg_t      cfg,
	output crcfc_pkg::result_t   res
);

	logic [crcfc_pkg::CNT_W-1:0] count_q;
	logic [15:0] crc_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [15:0] len_q;
	logic        cmd_ok_q;
	logic        neg_q;
	logic [15:0] stat_q;

	logic [15:0] len_d;
	logic        cmd_ok_d;
	logic        neg_d;
	logic [15:0] stat_d;
	logic [15:0] crc_d;
	logic [15:0] rx_crc;
	logic        crc_live;

	always_comb begin
		len_d    = len_q;
		cmd_ok_d = cmd_ok_q;
		neg_d    = neg_q;
		stat_d   = stat_q;
		case (count_q)
			4'd1: len_d[15:8] = rx_byte;
			4'd2: len_d[7:0]  = rx_byte;
			4'd3: neg_d       = (rx_byte == crcfc_pkg::NEG_RESP_CHAR);
			4'd4: if (rx_byte != cfg.cmd[15:8]) cmd_ok_d = 1'b0;
			4'd5: if (rx_byte != cfg.cmd[7:0]) cmd_ok_d = 1'b0;
			4'd6: stat_d[15:8] = rx_byte;
			4'd7: stat_d[7:0]  = rx_byte;
			default: ;
		endcase
	end

	// CRC runs two bytes behind, so the trailing CRC bytes never enter it
	assign crc_live = (count_q >= 4'd2);
	assign crc_d    = crc_live
		? crcfc_pkg::crc_byte((count_q == 4'd2) ? cfg.seed : crc_q, held0_q, cfg.poly)
		: crc_q;
	assign rx_crc   = {held1_q, rx_byte};

	always_comb begin
		res.device_status  = stat_d;
		res.computed_crc   = crc_live ? crc_d : cfg.seed;
		res.payload_length = 17'd0;
		if (count_q < crcfc_pkg::CNT_W'(crcfc_pkg::MIN_FRAME_BYTES - 1)) begin
			res.check_status = crcfc_pkg::CHK_SHORT;
		end else if (!cmd_ok_d) begin
			res.check_status = crcfc_pkg::CHK_CMD_MISM;
		end else if (rx_crc != crc_d) begin
			res.check_status = crcfc_pkg::CHK_CRC_MISM;
		end else if (neg_d) begin
			res.check_status = crcfc_pkg::CHK_NEG_RESP;
		end else begin
			res.check_status   = crcfc_pkg::CHK_OK;
			res.payload_length = {1'b0, len_d} + crcfc_pkg::LEN_EXTRA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= '0;
			held0_q  <= '0;
			held1_q  <= '0;
			len_q    <= '0;
			cmd_ok_q <= 1'b1;
			neg_q    <= 1'b0;
			stat_q   <= '0;
		end else if (adv) begin
			if (frame_end) begin
				// start over: next item is STX
				count_q  <= '0;
				crc_q    <= cfg.seed;
				held0_q  <= '0;
				held1_q  <= '0;
				len_q    <= '0;
				cmd_ok_q <= 1'b1;
				neg_q    <= 1'b0;
				stat_q   <= '0;
			end else begin
				if (count_q < crcfc_pkg::CNT_W'(crcfc_pkg::MIN_FRAME_BYTES)) begin
					count_q <= count_q + 1'b1;
				end
				crc_q    <= crc_d;
				held0_q  <= held1_q;
				held1_q  <= rx_byte;
				len_q    <= len_d;
				cmd_ok_q <= cmd_ok_d;
				neg_q    <= neg_d;
				stat_q   <= stat_d;
			end
		end
	end

endmodule

FILE: sv/crc16_response_frame_checker.sv
// Top level of the CRC-16 response frame checker.
// Usage:
//   Slave stream: one frame byte per item in s_tdata, s_tlast high on the
//   frame's final byte (the CRC low byte). Frame bytes are STX, LEN hi/lo,
//   P/N, CMD1, CMD2, STAT1, STAT2, data, CRC hi, CRC lo.
//   Master stream: one item per frame, produced for the final byte only, with
//   check status, device status, LEN+3 (zero unless ok) and the computed CRC.
//   APB port: polynomial, seed and expected command at 0x0, 0x4, 0x8; write
//   them only while no frame is in flight.
// Timing:
//   An accepted byte is held in the input register; the CRC step and
//   the checks run between that register and the output register, which
//   takes the result for m_tvalid as the final byte leaves the input. One byte per
//   cycle unless stalled; the byte-wide CRC step sets the clock path.
// Reset clears the frame state and both stream registers; the registers
// return to polynomial 0x1021, seed 0, command 0.
// When m_tready is low and a result waits, the input register still drains
// bytes that carry no result; s_tready drops only when it holds the next
// frame's final byte behind the waiting result.
module crc16_response_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] check_status, [18:3] device_status, [35:19] payload_length,
	// [51:36] computed_crc, [55:52] zero
	output logic [55:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	crcfc_pkg::cfg_t    cfg;
	crcfc_pkg::result_t res;
	crcfc_pkg::result_t res_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       adv;

	crcfc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// an item leaves s1 unless it carries a result and the output is blocked
	assign adv      = valid_s1 & (~last_s1 | ~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	crcfc_frame_check u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.rx_byte   (byte_s1),
		.frame_end (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, res_q.computed_crc, res_q.payload_length,
		res_q.device_status, res_q.check_status};

endmodule

FILE: sv/crcfc_checker.sv
// Port-level checks for the response frame checker, bound to the top level.
module crcfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// a result waiting on the receiver holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// length is reported only for a good frame
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != crcfc_pkg::CHK_OK) |-> (m_tdata[35:19] == 17'd0))
		else $error("length reported on a failed frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == crcfc_pkg::CHK_OK) |-> (m_tdata[35:19] >= 17'd3))
		else $error("length of a good frame below three");

	// a non-final byte never makes a result appear
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tvalid && s_tready && !s_tlast
			##1 !m_tvalid |=> !m_tvalid)
		else $error("result without a final byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:52] == 4'h0))
		else $error("padding bits set");

endmodule

bind crc16_response_frame_checker crcfc_checker u_crcfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
